// File: design/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg: shared definitions for the multi stack pool
// Field widths, operation and status codes, sequencer states and default
// sizes used by the multi stack pool core.
// ----------------------------------------------------------------------------
`default_nettype none

package msp_pkg;

  // default sizes
  localparam int RAILS_DEF      = 16;
  localparam int POOL_DEPTH_DEF = 1024;

  // request and result field widths
  localparam int OP_W      = 2;
  localparam int RAIL_IN_W = 4;
  localparam int LABEL_W   = 32;
  localparam int STATUS_W  = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
  localparam logic [OP_W-1:0] OP_POP     = 2'd1;
  localparam logic [OP_W-1:0] OP_MIGRATE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_SAME  = 2'd3;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_POP_T,
    S_POP_N,
    S_MIG_S,
    S_MIG_D,
    S_MIG_MV,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

// File: design/multi_stack_pool_with_migrate_core.sv
// ----------------------------------------------------------------------------
// multi_stack_pool_with_migrate_core: linked stacks in one shared node pool
// Push, pop and migrate on RAILS stacks whose entries are nodes of a shared
// pool, with a free list for returned nodes and a fresh-node counter.
// ----------------------------------------------------------------------------
// Every request produces exactly one result. The block takes one request at a
// time under a small sequencer built around a node pool memory with one read
// and one write port per cycle and a stack-top table with one read and one
// write port. The migrate walk of one node per cycle is set by the single
// node-link read port. A result waits in an output register, so the next
// request can be accepted while it is pending; if a new result is ready while
// the old one is still held, the sequencer waits one state until the output
// register frees up. The stack-top table has one valid bit per stack, so no
// clearing pass is needed after reset.
`default_nettype none

module multi_stack_pool_with_migrate_core
  import msp_pkg::*;
#(
  parameter int RAILS      = RAILS_DEF,
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // request channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [OP_W-1:0]            in_op,
  input  wire logic [RAIL_IN_W-1:0]       in_rail,
  input  wire logic signed [LABEL_W-1:0]  in_label,
  input  wire logic [RAIL_IN_W-1:0]       in_dest_rail,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [STATUS_W-1:0]             out_status,
  output logic                            out_popped_valid,
  output logic signed [LABEL_W-1:0]       out_popped_label
);

  localparam int RAIL_W = (RAILS > 1) ? $clog2(RAILS) : 1;
  localparam int IDX_W  = $clog2(POOL_DEPTH);
  localparam int PTR_W  = $clog2(POOL_DEPTH + 1);
  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_DEPTH);

  // helpers
  function automatic logic rail_ok(input logic [RAIL_IN_W-1:0] r);
    return (32'(r) < RAILS);
  endfunction

  function automatic logic [RAIL_W-1:0] to_rail(input logic [RAIL_IN_W-1:0] r);
    return RAIL_W'(r);
  endfunction

  // sequencer and request registers
  state_t                  state_r, state_nxt;
  logic [RAIL_IN_W-1:0]    rail_r, rail_nxt;
  logic [RAIL_IN_W-1:0]    dest_r, dest_nxt;
  logic [LABEL_W-1:0]      label_r, label_nxt;
  logic [PTR_W-1:0]        src_r, src_nxt;
  logic [PTR_W-1:0]        dst_r, dst_nxt;
  logic [PTR_W-1:0]        free_head_r, free_head_nxt;
  logic [PTR_W-1:0]        fresh_r, fresh_nxt;

  // output and pending result registers
  logic                    out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]     out_status_r;
  logic                    out_pvalid_r;
  logic [LABEL_W-1:0]      out_plabel_r;
  logic [STATUS_W-1:0]     pend_status_r;
  logic                    pend_pvalid_r;
  logic [LABEL_W-1:0]      pend_plabel_r;

  // memories
  logic [PTR_W-1:0]        top_mem [RAILS];
  logic [RAILS-1:0]        top_vld_r;
  logic [LABEL_W-1:0]      label_mem [POOL_DEPTH];
  logic [PTR_W-1:0]        next_mem [POOL_DEPTH];

  // memory ports
  logic [RAIL_W-1:0]       top_raddr;
  logic [PTR_W-1:0]        top_q;
  logic                    top_vq;
  logic                    top_we;
  logic [RAIL_W-1:0]       top_waddr;
  logic [PTR_W-1:0]        top_wdata;
  logic [PTR_W-1:0]        node_raddr;
  logic [LABEL_W-1:0]      label_q;
  logic [PTR_W-1:0]        next_q;
  logic                    label_we;
  logic [PTR_W-1:0]        label_waddr;
  logic                    next_we;
  logic [PTR_W-1:0]        next_waddr;
  logic [PTR_W-1:0]        next_wdata;

  // result handoff
  logic                    res_valid;
  logic [STATUS_W-1:0]     res_status;
  logic                    res_pvalid;
  logic [LABEL_W-1:0]      res_plabel;
  logic                    out_free;
  logic                    load_out;
  logic                    load_pend;

  logic [PTR_W-1:0]        top_eff;
  logic [PTR_W-1:0]        cur_dst;

  assign top_eff  = top_vq ? top_q : NIL;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_valid = out_pvalid_r;
  assign out_popped_label = out_plabel_r;

  // next state, memory controls and results
  always_comb begin
    state_nxt     = state_r;
    rail_nxt      = rail_r;
    dest_nxt      = dest_r;
    label_nxt     = label_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    free_head_nxt = free_head_r;
    fresh_nxt     = fresh_r;

    top_raddr   = to_rail(rail_r);
    top_we      = 1'b0;
    top_waddr   = to_rail(rail_r);
    top_wdata   = NIL;
    node_raddr  = free_head_r;
    label_we    = 1'b0;
    label_waddr = src_r;
    next_we     = 1'b0;
    next_waddr  = src_r;
    next_wdata  = NIL;

    res_valid  = 1'b0;
    res_status = STAT_OK;
    res_pvalid = 1'b0;
    res_plabel = '0;
    load_out   = 1'b0;
    load_pend  = 1'b0;
    cur_dst    = dst_r;

    case (state_r)
      // take a request and start the table and free-list reads
      S_IDLE: begin
        top_raddr  = to_rail(in_rail);
        node_raddr = free_head_r;
        if (in_valid) begin
          rail_nxt  = in_rail;
          dest_nxt  = in_dest_rail;
          label_nxt = in_label;
          case (in_op)
            OP_PUSH: begin
              if (rail_ok(in_rail)) begin
                state_nxt = S_PUSH;
              end else begin
                res_valid = 1'b1;
              end
            end
            OP_POP: begin
              if (rail_ok(in_rail)) begin
                state_nxt = S_POP_T;
              end else begin
                res_valid  = 1'b1;
                res_status = STAT_EMPTY;
              end
            end
            OP_MIGRATE: begin
              if (in_rail == in_dest_rail) begin
                res_valid  = 1'b1;
                res_status = STAT_SAME;
              end else if (rail_ok(in_rail) && rail_ok(in_dest_rail)) begin
                state_nxt = S_MIG_S;
              end else begin
                res_valid = 1'b1;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end

      // allocate a node and link it on top of the stack, or report a full pool
      S_PUSH: begin
        res_valid = 1'b1;
        if (free_head_r != NIL) begin
          free_head_nxt = next_q;
          label_we      = 1'b1;
          label_waddr   = free_head_r;
          next_we       = 1'b1;
          next_waddr    = free_head_r;
          next_wdata    = top_eff;
          top_we        = 1'b1;
          top_wdata     = free_head_r;
        end else if (fresh_r != NIL) begin
          fresh_nxt   = fresh_r + PTR_W'(1);
          label_we    = 1'b1;
          label_waddr = fresh_r;
          next_we     = 1'b1;
          next_waddr  = fresh_r;
          next_wdata  = top_eff;
          top_we      = 1'b1;
          top_wdata   = fresh_r;
        end else begin
          res_status = STAT_FULL;
        end
      end

      // check the top node and read it
      S_POP_T: begin
        if (top_eff == NIL) begin
          res_valid  = 1'b1;
          res_status = STAT_EMPTY;
        end else begin
          src_nxt    = top_eff;
          node_raddr = top_eff;
          state_nxt  = S_POP_N;
        end
      end

      // unlink the top node and return it to the free list
      S_POP_N: begin
        top_we        = 1'b1;
        top_wdata     = next_q;
        next_we       = 1'b1;
        next_waddr    = src_r;
        next_wdata    = free_head_r;
        free_head_nxt = src_r;
        res_valid     = 1'b1;
        res_pvalid    = 1'b1;
        res_plabel    = label_q;
      end

      // latch the source top, empty the source, read the destination top
      S_MIG_S: begin
        if (top_eff == NIL) begin
          res_valid = 1'b1;
        end else begin
          src_nxt    = top_eff;
          top_we     = 1'b1;
          top_wdata  = NIL;
          top_raddr  = to_rail(dest_r);
          node_raddr = top_eff;
          state_nxt  = S_MIG_D;
        end
      end

      // move one node per cycle from source to destination
      S_MIG_D, S_MIG_MV: begin
        cur_dst    = (state_r == S_MIG_D) ? top_eff : dst_r;
        next_we    = 1'b1;
        next_waddr = src_r;
        next_wdata = cur_dst;
        dst_nxt    = src_r;
        src_nxt    = next_q;
        if (next_q != NIL) begin
          node_raddr = next_q;
          state_nxt  = S_MIG_MV;
        end else begin
          top_we    = 1'b1;
          top_waddr = to_rail(dest_r);
          top_wdata = src_r;
          res_valid = 1'b1;
        end
      end

      // hand a held result to the output register
      S_OUT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // route a finished result to the output or hold it
    if (res_valid) begin
      if (out_free) begin
        load_out  = 1'b1;
        state_nxt = S_IDLE;
      end else begin
        load_pend = 1'b1;
        state_nxt = S_OUT;
      end
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= NIL;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
      top_vld_r   <= '0;
    end else begin
      free_head_r <= free_head_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
      if (top_we) begin
        top_vld_r[top_waddr] <= 1'b1;
      end
    end
  end

  // request and walk registers
  always_ff @(posedge clk) begin
    rail_r  <= rail_nxt;
    dest_r  <= dest_nxt;
    label_r <= label_nxt;
    src_r   <= src_nxt;
    dst_r   <= dst_nxt;
  end

  // output and pending result registers
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state_r == S_OUT) begin
        out_status_r <= pend_status_r;
        out_pvalid_r <= pend_pvalid_r;
        out_plabel_r <= pend_plabel_r;
      end else begin
        out_status_r <= res_status;
        out_pvalid_r <= res_pvalid;
        out_plabel_r <= res_plabel;
      end
    end
    if (load_pend) begin
      pend_status_r <= res_status;
      pend_pvalid_r <= res_pvalid;
      pend_plabel_r <= res_plabel;
    end
  end

  // stack-top table
  always_ff @(posedge clk) begin
    if (top_we) begin
      top_mem[top_waddr] <= top_wdata;
    end
    top_q  <= top_mem[top_raddr];
    top_vq <= top_vld_r[top_raddr];
  end

  // node label memory
  always_ff @(posedge clk) begin
    if (label_we) begin
      label_mem[label_waddr[IDX_W-1:0]] <= label_r;
    end
    label_q <= label_mem[node_raddr[IDX_W-1:0]];
  end

  // node link memory
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_waddr[IDX_W-1:0]] <= next_wdata;
    end
    next_q <= next_mem[node_raddr[IDX_W-1:0]];
  end

endmodule

`default_nettype wire

// File: bench/tb_multi_stack_pool_with_migrate_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_stack_pool_with_migrate_core: self-checking bench for the stack pool
// Drives push, pop, migrate and no-op requests, mirrors the linked stacks,
// free list and fresh-node counter in a scoreboard, and compares every result
// in order. Covers empty pops, same-rail and empty migrates, and a full pool.
// ----------------------------------------------------------------------------

module tb_multi_stack_pool_with_migrate_core
  import msp_pkg::*;
();

  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int LINK_W = $clog2(POOL_DEPTH_DEF + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH_DEF);

  typedef logic [LINK_W-1:0] link_t;

  typedef struct {
    logic [STATUS_W-1:0]        status;
    logic                       popped_valid;
    logic signed [LABEL_W-1:0]  popped_label;
  } stack_result_t;

  // mirror of the pool and the results still owed by the block
  class stack_pool_board;
    logic signed [LABEL_W-1:0] node_label [POOL_DEPTH_DEF];
    link_t                     node_next [POOL_DEPTH_DEF];
    link_t                     stack_top [RAILS_DEF];
    link_t                     free_head;
    link_t                     fresh_count;
    int                        full_count;
    int                        error_count;
    stack_result_t             awaited_results [$];

    function new();
      foreach (stack_top[r]) stack_top[r] = NULL_LINK;
      free_head   = NULL_LINK;
      fresh_count = '0;
      full_count  = 0;
      error_count = 0;
    endfunction

    // apply one accepted request and queue the result it must give
    function void note_request(logic [OP_W-1:0] op, logic [RAIL_IN_W-1:0] rail,
                               logic signed [LABEL_W-1:0] label,
                               logic [RAIL_IN_W-1:0] dest);
      stack_result_t res;
      link_t         n;
      bit            got;
      res.status       = STAT_OK;
      res.popped_valid = 1'b0;
      res.popped_label = '0;
      got              = 1'b0;
      case (op)
        OP_PUSH: begin
          if (rail < RAILS_DEF) begin
            // free list first, then the next fresh node
            if (free_head != NULL_LINK) begin
              n = free_head;
              free_head = node_next[n];
              got = 1'b1;
            end else if (fresh_count != NULL_LINK) begin
              n = fresh_count;
              fresh_count++;
              got = 1'b1;
            end
            if (got) begin
              node_label[n] = label;
              node_next[n]  = stack_top[rail];
              stack_top[rail] = n;
            end else begin
              res.status = STAT_FULL;
              full_count++;
            end
          end
        end
        OP_POP: begin
          n = (rail < RAILS_DEF) ? stack_top[rail] : NULL_LINK;
          if (n != NULL_LINK) begin
            res.popped_valid = 1'b1;
            res.popped_label = node_label[n];
            stack_top[rail] = node_next[n];
            node_next[n] = free_head;
            free_head = n;
          end else begin
            res.status = STAT_EMPTY;
          end
        end
        OP_MIGRATE: begin
          if (rail == dest) begin
            res.status = STAT_SAME;
          end else if (rail < RAILS_DEF && dest < RAILS_DEF) begin
            // relink one node at a time, order reverses
            while (stack_top[rail] != NULL_LINK) begin
              n = stack_top[rail];
              stack_top[rail] = node_next[n];
              node_next[n] = stack_top[dest];
              stack_top[dest] = n;
            end
          end
        end
        default: ;
      endcase
      awaited_results.push_back(res);
    endfunction

    // compare one result with the oldest one owed
    function void check_result(logic [STATUS_W-1:0] status, logic popped_valid,
                               logic signed [LABEL_W-1:0] popped_label);
      stack_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result with nothing outstanding: status %0d label %0d",
               status, popped_label);
        error_count++;
        return;
      end
      want = awaited_results.pop_front();
      if (status !== want.status) begin
        $error("out_status expected %0d actual %0d", want.status, status);
        error_count++;
      end
      if (popped_valid !== want.popped_valid) begin
        $error("out_popped_valid expected %0d actual %0d", want.popped_valid,
               popped_valid);
        error_count++;
      end
      if (popped_label !== want.popped_label) begin
        $error("out_popped_label expected %0d actual %0d", want.popped_label,
               popped_label);
        error_count++;
      end
    endfunction

    // a random non-empty stack, or any rail when all are empty
    function logic [RAIL_IN_W-1:0] busy_rail();
      logic [RAIL_IN_W-1:0] busy [$];
      foreach (stack_top[r]) begin
        if (stack_top[r] != NULL_LINK) busy.push_back(RAIL_IN_W'(r));
      end
      if (busy.size() == 0) return RAIL_IN_W'($urandom_range(RAILS_DEF - 1));
      return busy[$urandom_range(busy.size() - 1)];
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [OP_W-1:0]            in_op;
  logic [RAIL_IN_W-1:0]       in_rail;
  logic signed [LABEL_W-1:0]  in_label;
  logic [RAIL_IN_W-1:0]       in_dest_rail;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [STATUS_W-1:0]        out_status;
  logic                       out_popped_valid;
  logic signed [LABEL_W-1:0]  out_popped_label;

  int tx_idle_pct = 26;
  int rx_idle_pct = 80;

  stack_pool_board board = new();

  multi_stack_pool_with_migrate_core #(
    .RAILS      (RAILS_DEF),
    .POOL_DEPTH (POOL_DEPTH_DEF)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_rail          (in_rail),
    .in_label         (in_label),
    .in_dest_rail     (in_dest_rail),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_popped_valid (out_popped_valid),
    .out_popped_label (out_popped_label)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_status, out_popped_valid, out_popped_label);
  end

  // optional idle gap, then hold one request until it is taken
  task automatic issue(logic [OP_W-1:0] op, logic [RAIL_IN_W-1:0] rail,
                       logic signed [LABEL_W-1:0] label,
                       logic [RAIL_IN_W-1:0] dest);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_rail      <= rail;
    in_label     <= label;
    in_dest_rail <= dest;
    do @(posedge clk); while (!in_ready);
    board.note_request(op, rail, label, dest);
  endtask

  // low rails carry most of the traffic so stacks grow deep
  function automatic logic [RAIL_IN_W-1:0] pick_rail();
    return $urandom_range(1) ? RAIL_IN_W'($urandom_range(3))
                             : RAIL_IN_W'($urandom_range(RAILS_DEF - 1));
  endfunction

  function automatic logic signed [LABEL_W-1:0] pick_label();
    case ($urandom_range(11))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // one random request; push and pop weights in percent, migrate takes
  // the rest up to 97 percent and the last 3 percent are no-ops
  task automatic random_request(int push_pct, int pop_pct);
    int                   pick;
    logic [OP_W-1:0]      op;
    logic [RAIL_IN_W-1:0] rail;
    pick = $urandom_range(99);
    if (pick < push_pct) op = OP_PUSH;
    else if (pick < push_pct + pop_pct) op = OP_POP;
    else if (pick < 97) op = OP_MIGRATE;
    else op = OP_NOP;
    rail = pick_rail();
    if (op != OP_PUSH && $urandom_range(3) != 0) rail = board.busy_rail();
    issue(op, rail, pick_label(), pick_rail());
  endtask

  // stimulus
  initial begin
    int guard;
    in_valid     <= 1'b0;
    in_op        <= OP_PUSH;
    in_rail      <= '0;
    in_label     <= '0;
    in_dest_rail <= '0;
    rst_n        <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty cases, extreme labels, rail extremes, migrate both ways
    issue(OP_POP, 4'd0, 32'sd0, 4'd0);
    issue(OP_MIGRATE, 4'd3, 32'sd0, 4'd3);
    issue(OP_MIGRATE, 4'd5, 32'sd0, 4'd6);
    issue(OP_NOP, 4'd15, '1, 4'd15);
    issue(OP_PUSH, 4'd0, 32'sh7FFF_FFFF, 4'd15);
    issue(OP_PUSH, 4'd0, 32'sh8000_0000, 4'd0);
    issue(OP_PUSH, 4'd15, 32'sd0, 4'd0);
    issue(OP_PUSH, 4'd15, '1, 4'd0);
    issue(OP_PUSH, 4'd0, 32'sh5555_5555, 4'd0);
    issue(OP_MIGRATE, 4'd0, '1, 4'd15);
    issue(OP_MIGRATE, 4'd15, 32'sd0, 4'd15);
    issue(OP_POP, 4'd0, '1, 4'd15);
    issue(OP_POP, 4'd15, 32'sh2AAA_AAAA, 4'd0);
    issue(OP_POP, 4'd15, 32'sd0, 4'd0);
    issue(OP_PUSH, 4'd7, 32'sh1234_5678, 4'd0);
    issue(OP_MIGRATE, 4'd15, 32'sd0, 4'd7);
    issue(OP_POP, 4'd7, 32'sd0, 4'd0);
    issue(OP_POP, 4'd7, 32'sd0, 4'd0);
    issue(OP_POP, 4'd7, 32'sd0, 4'd0);
    issue(OP_MIGRATE, 4'd8, 32'sd0, 4'd9);

    // mixed traffic, slow receiver
    repeat (110) random_request(70, 20);

    // fill the pool until pushes are refused, slow sender
    tx_idle_pct = 80;
    rx_idle_pct = 26;
    guard = 0;
    while (board.full_count < 3 && guard < 3000) begin
      random_request(97, 0);
      guard++;
    end

    // drain and refill through the free list, no idling
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (40) random_request(38, 45);

    in_valid <= 1'b0;
    while (board.awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.error_count == 0 && board.awaited_results.size() == 0) begin
      $display("multi_stack_pool_with_migrate_core regression: pass");
    end else begin
      $display("multi_stack_pool_with_migrate_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200_000_000;
    $display("multi_stack_pool_with_migrate_core regression: fail");
    $finish;
  end

endmodule
